FILE: rtl/ltmq_pkg.sv
`default_nettype none

package ltmq_pkg;

	localparam int MAX_ENTRIES_DEF  = 1024;
	localparam int HEIGHT_WIDTH_DEF = 32;

	// fixed field widths of the stream items
	localparam int IDX_W       = 10;
	localparam int HEIGHT_IN_W = 32;
	localparam int COUNT_W     = 11;
	localparam int IN_DATA_W   = 56;
	localparam int OUT_DATA_W  = 16;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

	typedef enum logic {
		OP_LOAD,
		OP_QUERY
	} op_t;

	typedef enum logic [1:0] {
		ST_FOUND,
		ST_NONE,
		ST_RANGE
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_HA,
		S_SCAN,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/leftmost_taller_meeting_query_unit.sv
// load: no result; one item per cycle while idle and the output is free
// query out of range or with equal indices: result registered in the cycle after the item
// scanning query: reads the first height, then checks from the second index on until an
// entry is taller or count-1 is reached; the single memory read port paces the scan
// reset clears control state and sets building_count to 1024; the height table
// is not cleared and holds no valid data until loaded
`default_nettype none

module leftmost_taller_meeting_query_unit
	import ltmq_pkg::*;
#(
	parameter int MAX_ENTRIES  = MAX_ENTRIES_DEF,
	parameter int HEIGHT_WIDTH = HEIGHT_WIDTH_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// building_count
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [COUNT_W-1:0]    cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// first_index[9:0], second_index[19:10], height_value[51:20], zero pad
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// operation[0]
	input  wire logic [0:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// meet_index[9:0], zero pad
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// status[1:0]
	output logic [1:0]                 m_tuser
);

	localparam int AW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
	localparam int HW    = HEIGHT_WIDTH;

	state_t               state_q, state_d;
	logic [COUNT_W-1:0]   count_cfg_q;
	logic [CW-1:0]        count_w;
	logic [CW-1:0]        chk_q, chk_d;
	logic [CW-1:0]        next_w;
	logic [HW-1:0]        ha_q;
	status_t              res_status_q, res_status_d;
	logic [IDX_W-1:0]     res_idx_q, res_idx_d;
	logic                 res_ld;
	logic                 ha_ld;
	logic                 m_valid_q;
	status_t              m_status_q, out_status_d;
	logic [IDX_W-1:0]     m_idx_q, out_idx_d;
	logic                 out_ld;
	logic                 out_free;
	logic                 accept;

	logic [HW-1:0]        mem [MAX_ENTRIES];
	logic [HW-1:0]        rd_data_s1;
	logic [AW-1:0]        raddr;
	logic                 we;

	op_t                  op;
	logic [CW-1:0]        a_w, b_w, lo_w, hi_w;
	logic [HW-1:0]        wdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_cfg_q <= COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			count_cfg_q <= cfg_data;
		end
	end

	// active count is building_count clipped to the table depth
	always_comb begin
		if (CW'(count_cfg_q) > CW'(MAX_ENTRIES)) begin
			count_w = CW'(MAX_ENTRIES);
		end else begin
			count_w = CW'(count_cfg_q);
		end
	end

	assign op    = op_t'(s_tuser[0]);
	assign a_w   = CW'(s_tdata[IDX_W-1:0]);
	assign b_w   = CW'(s_tdata[2*IDX_W-1:IDX_W]);
	assign lo_w  = (a_w < b_w) ? a_w : b_w;
	assign hi_w  = (a_w < b_w) ? b_w : a_w;
	assign wdata = HW'(s_tdata[2*IDX_W+HEIGHT_IN_W-1:2*IDX_W]);
	assign next_w = CW'(chk_q + 1'b1);

	assign out_free = !m_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		state_d      = state_q;
		chk_d        = chk_q;
		ha_ld        = 1'b0;
		res_ld       = 1'b0;
		res_status_d = ST_NONE;
		res_idx_d    = '0;
		out_ld       = 1'b0;
		out_status_d = ST_NONE;
		out_idx_d    = '0;
		raddr        = chk_q[AW-1:0];
		we           = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (op == OP_LOAD) begin
						we = (a_w < CW'(MAX_ENTRIES));
					end else if (hi_w >= count_w) begin
						out_ld       = 1'b1;
						out_status_d = ST_RANGE;
					end else if (lo_w == hi_w) begin
						out_ld       = 1'b1;
						out_status_d = ST_FOUND;
						out_idx_d    = lo_w[IDX_W-1:0];
					end else begin
						raddr   = lo_w[AW-1:0];
						chk_d   = hi_w;
						state_d = S_HA;
					end
				end
			end
			S_HA: begin
				// height of the first position arrives, start reading the second
				ha_ld   = 1'b1;
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (rd_data_s1 > ha_q) begin
					res_ld       = 1'b1;
					res_status_d = ST_FOUND;
					res_idx_d    = chk_q[IDX_W-1:0];
					state_d      = S_DONE;
				end else if (next_w >= count_w) begin
					res_ld       = 1'b1;
					res_status_d = ST_NONE;
					state_d      = S_DONE;
				end else begin
					raddr = next_w[AW-1:0];
					chk_d = next_w;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_ld       = 1'b1;
					out_status_d = res_status_q;
					out_idx_d    = res_idx_q;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_ld) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_q <= chk_d;
		if (ha_ld) begin
			ha_q <= rd_data_s1;
		end
		if (res_ld) begin
			res_status_q <= res_status_d;
			res_idx_q    <= res_idx_d;
		end
		if (out_ld) begin
			m_status_q <= out_status_d;
			m_idx_q    <= out_idx_d;
		end
	end

	// height table, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[a_w[AW-1:0]] <= wdata;
		end
		rd_data_s1 <= mem[raddr];
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'(m_idx_q);
	assign m_tuser  = m_status_q;

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (chk_q < count_w))
		else $error("scan index beyond active count");

	a_ha_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_HA) |=> (state_q == S_SCAN))
		else $error("first height read not followed by scan");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && (m_status_q == ST_RANGE || m_status_q == ST_NONE)) |-> (m_idx_q == '0))
		else $error("meet index not zero without a match");

	a_done_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (m_valid_q && state_q == S_IDLE))
		else $error("finished query result not delivered to output");

endmodule

`default_nettype wire

FILE: tb/sv/ltmq_checker.sv
`timescale 1ns / 100ps

module ltmq_checker
	import ltmq_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	input  wire logic                  cfg_ready,
	input  wire logic [COUNT_W-1:0]    cfg_data,
	input  wire logic                  s_tvalid,
	input  wire logic                  s_tready,
	// first_index[9:0], second_index[19:10], height_value[51:20], zero pad
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// operation[0]
	input  wire logic [0:0]            s_tuser,
	input  wire logic                  m_tvalid,
	input  wire logic                  m_tready,
	// meet_index[9:0], zero pad
	input  wire logic [OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	input  wire logic [1:0]            m_tuser,
	output int                         pending,
	output int                         fail_count
);

	typedef struct packed {
		status_t              status;
		logic [IDX_W-1:0]     index;
	} meeting_t;

	logic [HEIGHT_IN_W-1:0] heights [MAX_ENTRIES_DEF];
	logic [COUNT_W-1:0]     building_count;
	meeting_t               meet_q [$];
	int                     mism_total = 0;

	function automatic meeting_t predict_meeting(input logic [IDX_W-1:0] p,
			input logic [IDX_W-1:0] q);
		logic [IDX_W-1:0] lo;
		logic [IDX_W-1:0] hi;
		int               lim;
		int               j;
		meeting_t         r;
		lo = (p < q) ? p : q;
		hi = (p < q) ? q : p;
		lim = (building_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(building_count);
		r.status = ST_NONE;
		r.index = '0;
		if (int'(hi) >= lim) begin
			r.status = ST_RANGE;
		end else if (lo == hi) begin
			r.status = ST_FOUND;
			r.index = lo;
		end else if (heights[hi] > heights[lo]) begin
			r.status = ST_FOUND;
			r.index = hi;
		end else begin
			// scan right of hi for the first entry taller than lo
			for (j = int'(hi) + 1; j < lim && r.status != ST_FOUND; j++) begin
				if (heights[j] > heights[lo]) begin
					r.status = ST_FOUND;
					r.index = IDX_W'(j);
				end
			end
		end
		return r;
	endfunction

	task automatic log_mismatch(input string what, input meeting_t want);
		mism_total++;
		if (mism_total <= 10) begin
			$display("ltmq_checker: %s: expected status %0d index %0d, got status %0d index %0d",
				what, want.status, want.index, m_tuser, m_tdata);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		meeting_t want;
		if (!arst_n) begin
			building_count = COUNT_RESET;
			meet_q.delete();
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				building_count = cfg_data;
			end
			// retire before pushing: a result never belongs to an item taken on the same edge
			if (m_tvalid && m_tready) begin
				if (meet_q.size() == 0) begin
					want = '0;
					log_mismatch("result with nothing outstanding", want);
				end else begin
					want = meet_q.pop_front();
					if (m_tuser !== want.status || m_tdata !== OUT_DATA_W'(want.index)) begin
						log_mismatch("wrong result", want);
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (op_t'(s_tuser[0]) == OP_LOAD) begin
					heights[s_tdata[IDX_W-1:0]] = s_tdata[2*IDX_W+HEIGHT_IN_W-1:2*IDX_W];
				end else begin
					meet_q.push_back(predict_meeting(s_tdata[IDX_W-1:0],
						s_tdata[2*IDX_W-1:IDX_W]));
				end
			end
			pending <= meet_q.size();
			fail_count <= mism_total;
		end
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import ltmq_pkg::*;

	localparam int LIMIT           = 8_000_000;
	localparam int ITEMS_PER_PHASE = 36;
	localparam int PHASES          = 12;
	localparam int PRELOAD         = 128;
	localparam int ALL_LOADED      = -1;
	localparam int PICK_SMALL      = -1;
	localparam int PICK_MID        = -2;
	localparam int PHASE_COUNT [PHASES] = '{2, 1024, PICK_SMALL, 1, PICK_SMALL, 0,
		PICK_MID, 2047, PICK_SMALL, PICK_MID, 5, 1024};

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_THIRD
	} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [COUNT_W-1:0]    cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// first_index[9:0], second_index[19:10], height_value[51:20], zero pad
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	// operation[0]
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// meet_index[9:0], zero pad
	logic [OUT_DATA_W-1:0] m_tdata;
	// status[1:0]
	logic [1:0]            m_tuser;

	int       pending;
	int       fail_count;
	int       cycles = 0;
	int       burst_left = 0;
	int       cur_count = 1024;
	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;
	int       rx_tick = 0;

	// heights sent so far, to keep queries on loaded entries
	logic [HEIGHT_IN_W-1:0] tb_height [MAX_ENTRIES_DEF];
	bit                     tb_loaded [MAX_ENTRIES_DEF];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	leftmost_taller_meeting_query_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	ltmq_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.pending   (pending),
		.fail_count(fail_count)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// result side: open stretches, coin-flip stalls, or ready one cycle in three
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(32, 256);
		end else begin
			rx_left <= rx_left - 1;
		end
		rx_tick <= rx_tick + 1;
		case (rx_mode)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= (rx_tick % 3 == 0);
		endcase
	end

	// mostly small heights so ties and long scans both happen
	function automatic logic [HEIGHT_IN_W-1:0] pick_height();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7) return HEIGHT_IN_W'($urandom_range(0, 15));
		if (r == 7) return HEIGHT_IN_W'($urandom);
		return (r == 8) ? '0 : '1;
	endfunction

	// first unloaded entry that a query would read, or ALL_LOADED
	function automatic int first_unloaded(input int p, input int q, input int lim);
		int lo;
		int hi;
		int j;
		lo = (p < q) ? p : q;
		hi = (p < q) ? q : p;
		if (hi >= lim || lo == hi) return ALL_LOADED;
		if (!tb_loaded[lo]) return lo;
		if (!tb_loaded[hi]) return hi;
		if (tb_height[hi] > tb_height[lo]) return ALL_LOADED;
		for (j = hi + 1; j < lim; j++) begin
			if (!tb_loaded[j]) return j;
			if (tb_height[j] > tb_height[lo]) return ALL_LOADED;
		end
		return ALL_LOADED;
	endfunction

	task automatic send_item(input op_t op, input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b, input logic [HEIGHT_IN_W-1:0] h);
		int gap;
		if (op == OP_LOAD) begin
			tb_height[a] = h;
			tb_loaded[a] = 1'b1;
		end
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk) s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {{(IN_DATA_W - 2*IDX_W - HEIGHT_IN_W){1'b0}}, h, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// stop sending and wait until every outstanding query has answered
	task automatic drain();
		@(negedge clk) s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic set_count(input int v);
		drain();
		// let any trailing load or scan settle before touching the register
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= COUNT_W'(v);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk) cfg_valid <= 1'b0;
		cur_count = v;
	endtask

	initial begin
		int                     i;
		int                     ph;
		int                     n;
		int                     active;
		int                     a;
		int                     b;
		int                     u;
		logic [HEIGHT_IN_W-1:0] h;
		repeat (6) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// load a prefix of the table; later queries only read loaded entries
		for (i = 0; i < PRELOAD; i++) begin
			h = pick_height();
			case (i)
				0: h = '1;
				1, PRELOAD - 1: h = '0;
				2: h = 7;
				3, 4: h = 9;
				5: h = 10;
				default: ;
			endcase
			send_item(OP_LOAD, IDX_W'(i), IDX_W'($urandom), h);
		end

		// equal indices at both ends of the full table
		send_item(OP_QUERY, IDX_W'(0), IDX_W'(0), '1);
		send_item(OP_QUERY, IDX_W'(1023), IDX_W'(1023), '0);

		// swapped order, max height never beaten, no meeting at the table end,
		// taller at b, tie at b then scan
		set_count(PRELOAD);
		send_item(OP_QUERY, IDX_W'(5), IDX_W'(0), pick_height());
		send_item(OP_QUERY, IDX_W'(PRELOAD - 1), IDX_W'(1), pick_height());
		send_item(OP_QUERY, IDX_W'(1), IDX_W'(2), pick_height());
		send_item(OP_QUERY, IDX_W'(4), IDX_W'(3), pick_height());

		set_count(1);
		send_item(OP_QUERY, IDX_W'(0), IDX_W'(0), pick_height());
		send_item(OP_QUERY, IDX_W'(0), IDX_W'(1), pick_height());
		send_item(OP_QUERY, IDX_W'(1023), IDX_W'(0), pick_height());
		// stored although beyond the count
		send_item(OP_LOAD, IDX_W'(700), IDX_W'(0), '1);

		set_count(0);
		send_item(OP_QUERY, IDX_W'(0), IDX_W'(0), pick_height());

		set_count(2047);
		send_item(OP_LOAD, IDX_W'(699), IDX_W'(0), HEIGHT_IN_W'(5));
		send_item(OP_LOAD, IDX_W'(1022), IDX_W'(0), HEIGHT_IN_W'(9));
		send_item(OP_LOAD, IDX_W'(1023), IDX_W'(0), HEIGHT_IN_W'(4));
		send_item(OP_QUERY, IDX_W'(699), IDX_W'(700), pick_height());
		// no meeting at the end of the clipped count
		send_item(OP_QUERY, IDX_W'(1023), IDX_W'(1022), pick_height());

		for (ph = 0; ph < PHASES; ph++) begin
			n = PHASE_COUNT[ph];
			if (n == PICK_SMALL) n = $urandom_range(3, 64);
			else if (n == PICK_MID) n = $urandom_range(65, 1023);
			set_count(n);
			active = (cur_count > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : cur_count;
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if ($urandom_range(0, 9) < 7) begin
					if (active > 0 && $urandom_range(0, 7) != 0) begin
						a = $urandom_range(0, active - 1);
						b = ($urandom_range(0, 5) == 0) ? a : $urandom_range(0, active - 1);
					end else begin
						a = $urandom_range(0, 1023);
						b = $urandom_range(0, 1023);
					end
					u = first_unloaded(a, b, active);
					if (u == ALL_LOADED) begin
						send_item(OP_QUERY, IDX_W'(a), IDX_W'(b), HEIGHT_IN_W'($urandom));
					end else begin
						// the query would read an unloaded entry, load that entry instead
						send_item(OP_LOAD, IDX_W'(u), IDX_W'($urandom), pick_height());
					end
				end else begin
					if (active > 0 && $urandom_range(0, 1) == 1) a = $urandom_range(0, active - 1);
					else a = $urandom_range(0, 1023);
					send_item(OP_LOAD, IDX_W'(a), IDX_W'($urandom), pick_height());
				end
			end
		end

		drain();
		repeat (1100) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/ltmq_pkg.sv
rtl/leftmost_taller_meeting_query_unit.sv
tb/sv/ltmq_checker.sv
tb/sv/testbench.sv
